/* hw/rtl/ctc_pkg.sv */
// Shared types and constants for the columnar transposition cipher unit.
`timescale 1ns / 1ps

package ctc_pkg;

    localparam int COLUMNS_DEF      = 5;
    localparam int BUFFER_BYTES_DEF = 64;

    // Byte counts, row counts and grid indexes never exceed 64, so 7 bits hold all of them.
    localparam int CNT_W       = 7;
    localparam int KEY_W       = 15;
    localparam int KEY_ENTRY_W = 3;
    localparam int KEY_SLOTS   = 8;
    localparam int CFG_W       = 15;
    localparam int CFG_IDX_W   = 1;

    localparam logic [7:0]       PAD_BYTE  = 8'h7A;
    localparam logic [KEY_W-1:0] KEY_RESET = 15'd22737;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION = 1'b0,
        CFG_KEY_ORDER = 1'b1
    } t_cfg_idx;

    // One finished message, handed from the front to the back.
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] rows;
        logic             dir;
        logic [KEY_W-1:0] key;
        logic             ovf;
    } t_job;

    // Write into the message store.
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } t_wr;

endpackage

/* hw/rtl/ctc_front.sv */
// Front end: configuration registers, byte intake, grid bookkeeping and job creation.
`timescale 1ns / 1ps

module ctc_front import ctc_pkg::*; #(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last,
    input  logic                 i_q_full,
    input  logic                 i_done,
    output logic                 o_push,
    output t_job                 o_job,
    output t_wr                  o_wr
);

    localparam int CAPACITY = (BUFFER_BYTES / COLUMNS) * COLUMNS;
    localparam int CW       = $clog2(COLUMNS);

    logic             r_dir;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rows, n_rows;
    logic [CW-1:0]    r_col, n_col;
    logic             r_drop, n_drop;
    logic             r_hold;
    logic             accept;
    logic             fits;

    assign o_ready = !r_hold && !i_q_full;
    assign accept  = i_valid && o_ready;
    assign fits    = r_count < CNT_W'(CAPACITY);

    always_comb begin
        n_count = r_count;
        n_rows  = r_rows;
        n_col   = r_col;
        n_drop  = r_drop;
        if (fits) begin
            n_count = r_count + 1'b1;
            if (r_col == CW'(COLUMNS - 1)) begin
                n_col  = '0;
                n_rows = r_rows + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end else begin
            n_drop = 1'b1;
        end
    end

    // Encryption pads a partial last row; decryption drops it.
    always_comb begin
        o_job.n    = n_count;
        o_job.dir  = r_dir;
        o_job.key  = r_key;
        o_job.ovf  = n_drop;
        o_job.rows = (r_dir == DIR_DECRYPT) ? n_rows
                                            : n_rows + CNT_W'(n_col != '0);
    end

    assign o_push = accept && i_last && (o_job.rows != '0);

    assign o_wr.en   = accept && fits;
    assign o_wr.addr = r_count;
    assign o_wr.data = i_data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_ENCRYPT;
            r_key   <= KEY_RESET;
            r_count <= '0;
            r_rows  <= '0;
            r_col   <= '0;
            r_drop  <= 1'b0;
            r_hold  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DIRECTION: r_dir <= i_cfg_data[0];
                    CFG_KEY_ORDER: r_key <= i_cfg_data[KEY_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_last) begin
                    r_count <= '0;
                    r_rows  <= '0;
                    r_col   <= '0;
                    r_drop  <= 1'b0;
                    r_hold  <= o_push;
                end else begin
                    r_count <= n_count;
                    r_rows  <= n_rows;
                    r_col   <= n_col;
                    r_drop  <= n_drop;
                end
            end else if (i_done) begin
                r_hold <= 1'b0;
            end
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("message byte count beyond capacity");

    a_done_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> r_hold)
        else $error("back end finished a message the front did not hand over");

endmodule

/* hw/rtl/ctc_job_fifo.sv */
// Two-entry queue of finished messages between the front and the back.
`timescale 1ns / 1ps

module ctc_job_fifo import ctc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    t_job            r_entry [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [PW:0]     r_fill;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_fill == (PW+1)'(DEPTH);
    assign o_empty = r_fill == '0;
    assign o_job   = r_entry[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

/* hw/rtl/ctc_back.sv */
// Back end: message store, transposed read sequencer and output register.
`timescale 1ns / 1ps

module ctc_back import ctc_pkg::*; #(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_wr        i_wr,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_done,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_overflow
);

    localparam int AW    = $clog2(BUFFER_BYTES);
    localparam int KEXTW = KEY_SLOTS * KEY_ENTRY_W;
    localparam int IW    = 2 * CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    logic [7:0]       r_store [BUFFER_BYTES];

    t_state           r_state;
    t_job             r_job;
    logic [CNT_W-1:0] r_outer;
    logic [CNT_W-1:0] r_inner;
    logic             r_rd_pend;
    logic             r_rd_pad;
    logic             r_rd_last;
    logic             r_rd_ovf;
    logic [7:0]       r_rd_data;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_ovf;

    logic             issue;
    logic             is_last;
    logic [CNT_W-1:0] outer_end;
    logic [CNT_W-1:0] inner_end;
    logic [2:0]       enc_col;
    logic [2:0]       dec_pos;
    logic [IW-1:0]    idx_wide;
    logic [CNT_W-1:0] rd_idx;

    function automatic logic [KEY_ENTRY_W-1:0] key_entry(input logic [KEY_W-1:0] key,
                                                         input logic [2:0] pos);
        logic [KEXTW-1:0] ext;
        ext = KEXTW'(key);
        return ext[pos*KEY_ENTRY_W +: KEY_ENTRY_W];
    endfunction

    // An entry outside 1..COLUMNS picks column 0.
    function automatic logic [2:0] find_col(input logic [KEY_W-1:0] key,
                                            input logic [2:0] k);
        logic [KEY_ENTRY_W-1:0] v;
        v = key_entry(key, k);
        if (v != '0 && 4'(v) <= 4'(COLUMNS)) begin
            return v - 1'b1;
        end
        return 3'd0;
    endfunction

    // Lowest key position that holds j+1; position 0 when none does.
    function automatic logic [2:0] find_pos(input logic [KEY_W-1:0] key,
                                            input logic [2:0] j);
        logic [2:0] p;
        p = 3'd0;
        for (int i = COLUMNS - 1; i >= 0; i--) begin
            if (4'(key_entry(key, 3'(i))) == 4'(j) + 4'd1) begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

    assign enc_col = find_col(r_job.key, r_outer[2:0]);
    assign dec_pos = find_pos(r_job.key, r_inner[2:0]);

    always_comb begin
        if (r_job.dir == DIR_DECRYPT) begin
            outer_end = r_job.rows - 1'b1;
            inner_end = CNT_W'(COLUMNS - 1);
            idx_wide  = IW'(r_outer) + IW'(dec_pos) * IW'(r_job.rows);
        end else begin
            outer_end = CNT_W'(COLUMNS - 1);
            inner_end = r_job.rows - 1'b1;
            idx_wide  = IW'(r_inner) * IW'(COLUMNS) + IW'(enc_col);
        end
    end

    assign rd_idx  = idx_wide[CNT_W-1:0];
    assign is_last = (r_outer == outer_end) && (r_inner == inner_end);
    assign issue   = (r_state == ST_RUN) && !r_rd_pend && (!r_out_valid || i_ready);
    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_done  = issue && is_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (issue) begin
            r_rd_data <= r_store[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (issue) begin
            r_rd_pad  <= !(rd_idx < r_job.n);
            r_rd_last <= is_last;
            r_rd_ovf  <= r_job.ovf;
        end
        if (r_rd_pend) begin
            r_out_byte <= r_rd_pad ? PAD_BYTE : r_rd_data;
            r_out_last <= r_rd_last;
            r_out_ovf  <= r_rd_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_outer     <= '0;
            r_inner     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= issue;
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_outer <= '0;
                        r_inner <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        if (r_inner == inner_end) begin
                            r_inner <= '0;
                            r_outer <= r_outer + 1'b1;
                        end else begin
                            r_inner <= r_inner + 1'b1;
                        end
                        if (is_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;
    assign o_overflow = r_out_ovf;

    a_dec_in_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && r_job.dir == DIR_DECRYPT) |-> (rd_idx < r_job.n))
        else $error("decrypt read beyond the received bytes");

    a_run_has_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_job.rows != '0))
        else $error("sequencer running on an empty grid");

    a_read_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_rd_pend && !issue)
        else $error("store read not followed by its load");

endmodule

/* hw/rtl/columnar_transposition_cipher_unit.sv */
// Top level of the columnar transposition cipher unit.
`timescale 1ns / 1ps
// Input: one byte per cycle while a message is being loaded; after the last byte of a message
// that yields output the input stalls until its final result byte has been read from the store.
// Output: a new store read is issued only after the previous one has reached the output register,
// and only while the output is free; the first result byte passes queue, store read and output stage.
// Reset (synchronous, active low) clears counters, flags, queue and configuration
// (encrypt, key 1,2,3,4,5); the message store itself is not cleared.

module columnar_transposition_cipher_unit import ctc_pkg::*; #(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last,
    output logic                 o_overflow
);

    // The front collects the bytes of a message into the store and tracks the grid shape
    // as it goes, so no division is needed. On the last item it hands a job descriptor
    // (length, rows, mode, key, overflow) to the queue. The back walks the grid in
    // column order for encryption or row order for decryption and emits one item
    // per store read. A message that yields no output never enters the queue.

    t_job q_in_job;
    t_job q_out_job;
    t_wr  store_wr;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic back_done;

    ctc_front #(
        .COLUMNS      (COLUMNS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .i_done      (back_done),
        .o_push      (q_push),
        .o_job       (q_in_job),
        .o_wr        (store_wr)
    );

    ctc_job_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ctc_back #(
        .COLUMNS      (COLUMNS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (store_wr),
        .i_job      (q_out_job),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .o_done     (back_done),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last),
        .o_overflow (o_overflow)
    );

endmodule

/* test/ctc_transpose_monitor.sv */
// Scoreboard that predicts and checks every result item of the cipher unit.
`timescale 1ns / 1ps

module ctc_transpose_monitor import ctc_pkg::*; #(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    input  logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  logic [7:0]           o_out_byte,
    input  logic                 o_out_last,
    input  logic                 o_overflow,
    output logic [31:0]          o_fail_count,
    output logic [31:0]          o_pending
);

    localparam int CAPACITY      = (BUFFER_BYTES / COLUMNS) * COLUMNS;
    localparam int KEY_POSITIONS = KEY_W / KEY_ENTRY_W;
    localparam int AW            = $clog2(BUFFER_BYTES);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       overflow;
    } t_cipher_out;

    t_cipher_out      cipher_queue[$];
    t_cipher_out      want;
    logic [7:0]       grid_mem [0:BUFFER_BYTES-1];
    logic [CNT_W-1:0] held_count;
    logic             dropped;
    logic             dir_mode;
    logic [KEY_W-1:0] key_reg;
    int               fails;

    initial begin
        fails        = 0;
        o_fail_count = '0;
        o_pending    = '0;
    end

    // Positions beyond the packed register read as zero, an invalid entry.
    function automatic logic [KEY_ENTRY_W-1:0] key_slot(input logic [KEY_W-1:0] key,
                                                        input int pos);
        if (pos >= KEY_POSITIONS) return '0;
        return key[KEY_ENTRY_W*pos +: KEY_ENTRY_W];
    endfunction

    // Grid column emitted as output block k; bad entries fall back to column 0.
    function automatic int read_column(input logic [KEY_W-1:0] key, input int k);
        logic [KEY_ENTRY_W-1:0] v;
        v = key_slot(key, k);
        if (v >= 1 && v <= COLUMNS) return int'(v) - 1;
        return 0;
    endfunction

    // Received block that feeds output column j; position 0 if no slot holds j+1.
    function automatic int source_block(input logic [KEY_W-1:0] key, input int j);
        for (int p = 0; p < COLUMNS; p++)
            if (int'(key_slot(key, p)) == j + 1) return p;
        return 0;
    endfunction

    task automatic queue_cipher_burst();
        int          n;
        int          rows;
        int          idx;
        int          pos;
        t_cipher_out item;
        n = int'(held_count);
        if (dir_mode == DIR_ENCRYPT) begin
            rows = (n + COLUMNS - 1) / COLUMNS;
            for (int c = 0; c < COLUMNS; c++) begin
                pos = read_column(key_reg, c);
                for (int r = 0; r < rows; r++) begin
                    idx           = r * COLUMNS + pos;
                    item.out_byte = (idx < n) ? grid_mem[AW'(idx)] : PAD_BYTE;
                    item.out_last = (c == COLUMNS - 1) && (r == rows - 1);
                    item.overflow = dropped;
                    cipher_queue.push_back(item);
                end
            end
        end else begin
            rows = n / COLUMNS;
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < COLUMNS; c++) begin
                    idx           = r + source_block(key_reg, c) * rows;
                    item.out_byte = (idx < n) ? grid_mem[AW'(idx)] : PAD_BYTE;
                    item.out_last = (r == rows - 1) && (c == COLUMNS - 1);
                    item.overflow = dropped;
                    cipher_queue.push_back(item);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = '0;
            dropped    = 1'b0;
            dir_mode   = DIR_ENCRYPT;
            key_reg    = KEY_RESET;
            cipher_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DIRECTION) dir_mode = i_cfg_data[0];
                else if (i_cfg_idx == CFG_KEY_ORDER) key_reg = i_cfg_data[KEY_W-1:0];
            end
            if (o_valid && i_ready) begin
                if (cipher_queue.size() == 0) begin
                    $error("unexpected result item: out_byte %02h out_last %0b overflow %0b",
                           o_out_byte, o_out_last, o_overflow);
                    fails++;
                end else begin
                    want = cipher_queue.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               want.out_byte, o_out_byte);
                        fails++;
                    end
                    if (o_out_last !== want.out_last) begin
                        $error("out_last: expected %0b, actual %0b",
                               want.out_last, o_out_last);
                        fails++;
                    end
                    if (o_overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, o_overflow);
                        fails++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                if (held_count < CAPACITY) begin
                    grid_mem[held_count[AW-1:0]] = i_data_byte;
                    held_count                   = held_count + 1'b1;
                end else begin
                    dropped = 1'b1;
                end
                if (i_last) begin
                    queue_cipher_burst();
                    held_count = '0;
                    dropped    = 1'b0;
                end
            end
        end
        o_fail_count <= 32'(fails);
        o_pending    <= 32'(cipher_queue.size());
    end

endmodule

/* test/tb_columnar_transposition_cipher_unit.sv */
// Testbench top for the columnar transposition cipher unit: stimulus and verdict.
`timescale 1ns / 1ps

module tb_columnar_transposition_cipher_unit;
    import ctc_pkg::*;

    // Every input of the block starts from a known value at time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_DIRECTION;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [7:0]           i_data_byte = '0;
    logic                 i_last      = 1'b0;
    logic                 i_ready     = 1'b0;

    wire                  o_ready;
    wire                  o_valid;
    wire [7:0]            o_out_byte;
    wire                  o_out_last;
    wire                  o_overflow;
    wire [31:0]           fail_count;
    wire [31:0]           pending_results;

    // Stimulus bookkeeping shared between the sender and the receiver processes.
    int items_sent   = 0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    columnar_transposition_cipher_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_overflow  (o_overflow)
    );

    // The monitor sees the same pins as the block and keeps its own copy of the state.
    ctc_transpose_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_overflow   (o_overflow),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #10 i_clk = ~i_clk;

    // Packs five key entries, the first one in the lowest bits.
    function automatic logic [KEY_W-1:0] pack_key(input logic [2:0] k0, input logic [2:0] k1,
                                                  input logic [2:0] k2, input logic [2:0] k3,
                                                  input logic [2:0] k4);
        return {k4, k3, k2, k1, k0};
    endfunction

    // A random permutation of 1..5, which is the well-formed kind of key.
    function automatic logic [KEY_W-1:0] shuffled_key();
        int               order[COLUMNS_DEF];
        int               j;
        int               t;
        logic [KEY_W-1:0] key;
        for (int i = 0; i < COLUMNS_DEF; i++) order[i] = i + 1;
        for (int i = COLUMNS_DEF - 1; i > 0; i--) begin
            j        = int'($urandom_range(0, i));
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        key = '0;
        for (int i = 0; i < COLUMNS_DEF; i++) begin
            key[KEY_ENTRY_W*i +: KEY_ENTRY_W] = KEY_ENTRY_W'(order[i]);
        end
        return key;
    endfunction

    // Offers one item and returns at the edge where it is accepted. An idle burst may come
    // first; otherwise valid stays high from the previous item, so it is never dropped and
    // raised again within one time step.
    task automatic send_byte(input logic [7:0] data, input logic is_last);
        if (items_sent > 320) calm = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_last      <= is_last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // Stops offering, waits for every expected result, then lets the pipeline of the block drain
    // so that a message with no results has surely been dealt with too.
    task automatic finish_phase();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Writes the direction and then the key register on back-to-back edges; the upper direction bits are junk.
    task automatic write_config(input logic dir, input logic [KEY_W-1:0] key);
        logic [CFG_W-2:0] junk;
        junk = (CFG_W-1)'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DIRECTION;
        i_cfg_data <= {junk, dir};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEY_ORDER;
        i_cfg_data <= key;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Receiver: random ready bursts, one long hold-off on request, and no stalls once the
    // run has turned calm. Each pass makes one assignment to ready and then lets time pass.
    initial begin
        wait (i_rst_n);
        forever begin
            if (hold_request && !hold_done) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int               len;
        int               msgs;
        int               phase;
        int               pick;
        logic             dir;
        logic [KEY_W-1:0] key;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, encrypt with the identity key: a single byte padded to one full
        // row, then a message that fills its rows exactly and needs no padding.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b1);
        finish_phase();

        // A scrambled key with a partial last row, so padding lands in several columns.
        write_config(DIR_ENCRYPT, pack_key(3'd3, 3'd5, 3'd1, 3'd4, 3'd2));
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        finish_phase();

        // Decrypt shorter than one row gives nothing at all.
        write_config(DIR_DECRYPT, pack_key(3'd3, 3'd5, 3'd1, 3'd4, 3'd2));
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h99, 1'b1);
        finish_phase();

        // Decrypt with a leftover byte past the last full row, which is dropped.
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h66, 1'b1);
        finish_phase();

        // All-zero key in encrypt: every entry is invalid and selects column zero.
        write_config(DIR_ENCRYPT, '0);
        send_byte(8'hE7, 1'b0);
        send_byte(8'h18, 1'b1);
        finish_phase();

        // All-ones key in decrypt: no position holds any column number.
        write_config(DIR_DECRYPT, '1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h10, 1'b1);
        finish_phase();

        // Random phases: mostly proper permutation keys, now and then raw or extreme keys.
        // The first phase overflows the store, the third holds the receiver off for a long
        // stretch while two long messages are offered back to back.
        phase = 0;
        while (items_sent < 370) begin
            calm = (items_sent > 320) || (phase % 5 == 4);
            pick = int'($urandom_range(0, 9));
            dir  = 1'($urandom_range(0, 1));
            if (pick == 0) key = $urandom_range(0, 1) ? '1 : '0;
            else if (pick < 3) key = KEY_W'($urandom);
            else key = shuffled_key();
            write_config(dir, key);
            if (phase == 0) begin
                send_message(64);
            end else if (phase == 2) begin
                hold_request = 1'b1;
                send_message(40);
                send_message(40);
            end else begin
                msgs = int'($urandom_range(1, 4));
                for (int m = 0; m < msgs; m++) begin
                    pick = int'($urandom_range(0, 9));
                    len  = (pick == 0) ? int'($urandom_range(55, 70))
                                       : int'($urandom_range(1, 20));
                    send_message(len);
                end
            end
            finish_phase();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_columnar_transposition_cipher_unit: done, clean");
        end else begin
            $display("tb_columnar_transposition_cipher_unit: done, errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #100_000_000;
        $display("tb_columnar_transposition_cipher_unit: done, errors");
        $finish;
    end

endmodule
